>>> rtl/core/xalu_pkg.sv
// shared types and constants for the x86 integer alu
// no dependencies
package xalu_pkg;

	localparam int unsigned QueueDepth = 2;

	typedef enum logic [3:0] {
		OP_ADD  = 4'd0,
		OP_ADC  = 4'd1,
		OP_SUB  = 4'd2,
		OP_SBB  = 4'd3,
		OP_AND  = 4'd4,
		OP_OR   = 4'd5,
		OP_XOR  = 4'd6,
		OP_SHL  = 4'd7,
		OP_SHR  = 4'd8,
		OP_SAR  = 4'd9,
		OP_MUL  = 4'd10,
		OP_IMUL = 4'd11
	} op_t;

	localparam logic [1:0] SZ_8  = 2'd0;
	localparam logic [1:0] SZ_16 = 2'd1;

	// decoded operation handed from front to back
	typedef struct packed {
		logic        known;
		logic [3:0]  cmd;
		logic [1:0]  sz;
		logic [31:0] s;
		logic [31:0] d;
	} op_item_t;

	typedef struct packed {
		logic        of;
		logic        sf;
		logic        zf;
		logic        pf;
		logic        cf;
	} flags_t;

	function automatic logic [31:0] size_mask(input logic [1:0] sz);
		logic [31:0] m;
		case (sz)
			SZ_8:    m = 32'h0000_00FF;
			SZ_16:   m = 32'h0000_FFFF;
			default: m = 32'hFFFF_FFFF;
		endcase
		return m;
	endfunction

endpackage

>>> rtl/core/xalu_front.sv
// front end: masks operands to size and flags unknown commands
// depends on xalu_pkg
module xalu_front import xalu_pkg::*; (
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,
	output logic        push,
	output op_item_t    push_item,
	input  logic        q_full
);
	logic [31:0] m;

	assign s_tready = !q_full;
	assign push = s_tvalid && s_tready;
	assign m = size_mask(s_tdata[69:68]);

	always_comb begin
		push_item.cmd = s_tdata[3:0];
		push_item.known = (s_tdata[3:0] <= OP_IMUL);
		push_item.sz = s_tdata[69:68];
		// shift count needs the raw low bits, masking keeps them
		push_item.s = s_tdata[35:4] & m;
		push_item.d = s_tdata[67:36] & m;
	end
endmodule

>>> rtl/core/xalu_queue.sv
// short fifo between front and back
// depends on xalu_pkg
module xalu_queue import xalu_pkg::*; #(
	parameter int unsigned Depth = QueueDepth
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  op_item_t push_item,
	output logic     full,
	input  logic     pop,
	output logic     empty,
	output op_item_t head
);
	localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

	op_item_t mem_q [Depth];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;

	assign full = (cnt_q == (AW+1)'(Depth));
	assign empty = (cnt_q == '0);
	assign head = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == AW'(Depth-1)) ? '0 : wp_q + 1'b1;
			if (pop) rp_q <= (rp_q == AW'(Depth-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end
endmodule

>>> rtl/core/xalu_back.sv
// back end: one op per cycle unless stalled, holds flag register and output stage
// depends on xalu_pkg
module xalu_back import xalu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        empty,
	input  op_item_t    head,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata
);
	flags_t fl_q, nf;
	logic [63:0] res;
	logic [63:0] res_s1;
	logic valid_s1;
	logic [5:0] w;
	logic [4:0] msb;
	logic [32:0] sum;
	logic [33:0] diff;
	logic [63:0] wide, sd, sh, ss;
	logic [4:0] cnt;
	logic cin, c_bit, of_bit, top_r, hi;
	logic [31:0] r32, m, ovf;
	logic [63:0] prod;
	logic upd;

	assign pop = !empty && (!valid_s1 || m_tready);

	always_comb begin
		case (head.sz)
			SZ_8: begin
				w = 6'd8;
				msb = 5'd7;
			end
			SZ_16: begin
				w = 6'd16;
				msb = 5'd15;
			end
			default: begin
				w = 6'd32;
				msb = 5'd31;
			end
		endcase
		m = size_mask(head.sz);
		cin = fl_q.cf;
		cnt = head.s[4:0];
		sum = '0;
		diff = '0;
		wide = '0;
		sd = '0;
		sh = '0;
		ss = '0;
		prod = '0;
		res = '0;
		ovf = '0;
		hi = 1'b0;
		c_bit = 1'b0;
		of_bit = 1'b0;
		upd = 1'b0;
		case (head.cmd)
			OP_ADD, OP_ADC: begin
				sum = {1'b0, head.d} + {1'b0, head.s}
					+ 33'((head.cmd == OP_ADC) && cin);
				res = {32'd0, sum[31:0] & m};
				c_bit = sum[w];
				ovf = ~(head.d ^ head.s) & (head.d ^ res[31:0]);
				of_bit = ovf[msb];
				upd = 1'b1;
			end
			OP_SUB, OP_SBB: begin
				diff = {2'b0, head.d} - {2'b0, head.s}
					- 34'((head.cmd == OP_SBB) && cin);
				res = {32'd0, diff[31:0] & m};
				c_bit = diff[33];
				ovf = (head.d ^ head.s) & (head.d ^ res[31:0]);
				of_bit = ovf[msb];
				upd = 1'b1;
			end
			OP_AND: begin res = {32'd0, head.d & head.s}; upd = 1'b1; end
			OP_OR:  begin res = {32'd0, head.d | head.s}; upd = 1'b1; end
			OP_XOR: begin res = {32'd0, head.d ^ head.s}; upd = 1'b1; end
			OP_SHL, OP_SHR, OP_SAR: begin
				res = {32'd0, head.d};
				if (cnt != 5'd0) begin
					upd = 1'b1;
					sd = {32'd0, head.d};
					if (head.cmd == OP_SHL) begin
						wide = sd << cnt;
						c_bit = wide[w];
						res = {32'd0, wide[31:0] & m};
						of_bit = res[w - 6'd1] ^ c_bit;
					end else if (head.cmd == OP_SHR) begin
						res = sd >> cnt;
						c_bit = head.d[cnt - 5'd1];
						of_bit = head.d[msb];
					end else begin
						ss = {{32{head.d[msb]}}, head.d | ~m};
						if (!head.d[msb]) ss = sd;
						sh = $signed(ss) >>> cnt;
						res = {32'd0, sh[31:0] & m};
						c_bit = ss[{1'b0, cnt - 5'd1}];
					end
				end
			end
			OP_MUL: begin
				prod = {32'd0, head.d} * {32'd0, head.s};
				res = prod;
				hi = ((prod >> w) != 64'd0);
				c_bit = hi;
				of_bit = hi;
				upd = 1'b1;
			end
			OP_IMUL: begin
				ss = {{32{head.d[msb]}}, head.d | (head.d[msb] ? ~m : 32'd0)};
				sd = {{32{head.s[msb]}}, head.s | (head.s[msb] ? ~m : 32'd0)};
				prod = 64'($signed(ss[31:0]) * $signed(sd[31:0]));
				res = prod & ({m, 32'd0} >> (6'd32 - w) | {32'd0, m});
			end
			default: res = '0;
		endcase
		r32 = res[31:0] & m;
		top_r = r32[msb];
		nf = fl_q;
		if (upd) begin
			nf.cf = c_bit;
			nf.of = of_bit;
			nf.pf = ~^r32[7:0];
			nf.zf = (r32 == 32'd0);
			nf.sf = top_r;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) res_s1 <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fl_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (pop) fl_q <= nf;
			if (pop) valid_s1 <= 1'b1;
			else if (m_tready) valid_s1 <= 1'b0;
		end
	end

	assign m_tvalid = valid_s1;
	assign m_tdata = {3'd0, fl_q.of, fl_q.sf, fl_q.zf, fl_q.pf, fl_q.cf, res_s1};
endmodule

>>> rtl/core/x86_integer_alu_with_flags.sv
// x86 integer alu with flags: one operation per cycle at 8/16/32 bits while m_tready
// is high. Each op waits in a two-entry queue; the back end executes it and updates
// CF/PF/ZF/SF/OF except for IMUL, zero-count shifts and unknown commands. The result
// is registered and appears in the cycle after the op leaves the queue.
// depends on xalu_pkg, xalu_front, xalu_queue, xalu_back
module x86_integer_alu_with_flags import xalu_pkg::*; #(
	parameter int unsigned Depth = QueueDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata, // command[3:0], src_operand[35:4], dest_operand[67:36], size_code[69:68]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata  // result_value[63:0], cf, pf, zf, sf, of [68:64]
);
	logic push, pop, full, empty;
	op_item_t push_item, head;

	xalu_front u_front (.s_tvalid, .s_tready, .s_tdata,
		.push, .push_item, .q_full(full));
	xalu_queue #(.Depth(Depth)) u_queue (.clk, .arst_n, .push, .push_item, .full,
		.pop, .empty, .head);
	xalu_back u_back (.clk, .arst_n, .empty, .head, .pop, .m_tvalid, .m_tready, .m_tdata);
endmodule

>>> rtl/core/xalu_checker.sv
// port-level checker for the alu
// depends on x86_integer_alu_with_flags ports
module xalu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("out beat dropped");
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[71:69] == 3'd0) else $error("pad bits set");
	// a zero result has no sign bit and even parity
	a_zf: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[66] |-> !m_tdata[67] && m_tdata[65])
		else $error("flags");
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready) else $error("stalled while output empty");
endmodule

bind x86_integer_alu_with_flags xalu_checker u_chk (.*);
